FILE: design/shc_pkg.sv
// Shared types and constants for the state image header checker.
package shc_pkg;

	localparam int unsigned POS_W = 5;

	localparam logic [POS_W-1:0] HDR_MAGIC_END   = 5'd8;
	localparam logic [POS_W-1:0] HDR_VERSION_END = 5'd12;
	localparam logic [POS_W-1:0] HDR_LENGTH_END  = 5'd20;
	localparam logic [POS_W-1:0] HDR_END         = 5'd24;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;

	localparam logic [31:0] VERSION_RESET = 32'd1;

	localparam logic [7:0] MAGIC [8] = '{8'h41, 8'h59, 8'h54, 8'h48,
		8'h53, 8'h54, 8'h41, 8'h54};

	typedef enum logic [2:0] {
		V_LOADED    = 3'd0,
		V_LEGACY    = 3'd1,
		V_TRUNCATED = 3'd2,
		V_BAD_VER   = 3'd3,
		V_LEN_MISM  = 3'd4,
		V_CSUM_MISM = 3'd5
	} verdict_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [31:0] found_version;
		logic [63:0] declared_length;
		logic [31:0] payload_bytes_seen;
	} shc_result_t;

endpackage

FILE: design/shc_image_tracker.sv
// Per-image header parse, FNV-1a fold, payload count and verdict logic.
module shc_image_tracker #(
	parameter int unsigned COUNT_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            data_byte,
	input  logic                  is_last,
	input  logic [31:0]           expected_version,
	output shc_pkg::shc_result_t  res
);

	logic [shc_pkg::POS_W-1:0] pos_q, pos_n;
	logic                      legacy_q, legacy_n;
	logic [31:0]               ver_q, ver_n;
	logic [63:0]               len_q, len_n;
	logic [31:0]               csum_q, csum_n;
	logic [31:0]               hash_q, hash_n;
	logic [COUNT_BITS-1:0]     cnt_q, cnt_n;
	logic [63:0]               cnt_wide;
	logic [2:0]                len_idx;

	assign len_idx  = 3'(pos_q - shc_pkg::HDR_VERSION_END);
	assign cnt_wide = 64'(cnt_n);

	always_comb begin
		pos_n    = pos_q;
		legacy_n = legacy_q;
		ver_n    = ver_q;
		len_n    = len_q;
		csum_n   = csum_q;
		hash_n   = hash_q;
		cnt_n    = cnt_q;
		if (legacy_q) begin
			// rest of a legacy image is ignored
		end else if (pos_q < shc_pkg::HDR_MAGIC_END) begin
			if (data_byte != shc_pkg::MAGIC[pos_q[2:0]])
				legacy_n = 1'b1;
			else
				pos_n = pos_q + 1'b1;
		end else if (pos_q < shc_pkg::HDR_VERSION_END) begin
			ver_n[{pos_q[1:0], 3'b000} +: 8] = data_byte;
			pos_n = pos_q + 1'b1;
		end else if (pos_q < shc_pkg::HDR_LENGTH_END) begin
			len_n[{len_idx, 3'b000} +: 8] = data_byte;
			pos_n = pos_q + 1'b1;
		end else if (pos_q < shc_pkg::HDR_END) begin
			// checksum starts at byte 20, so the low two bits give the lane
			csum_n[{pos_q[1:0], 3'b000} +: 8] = data_byte;
			pos_n = pos_q + 1'b1;
		end else begin
			hash_n = 32'((hash_q ^ {24'd0, data_byte}) * shc_pkg::FNV_PRIME);
			if (cnt_q != '1)
				cnt_n = cnt_q + 1'b1;
		end
	end

	// verdict sees the state as it stands after this beat
	always_comb begin
		res.verdict            = shc_pkg::V_LOADED;
		res.found_version      = '0;
		res.declared_length    = '0;
		res.payload_bytes_seen = '0;
		if (legacy_n || pos_n < shc_pkg::HDR_MAGIC_END) begin
			res.verdict = shc_pkg::V_LEGACY;
		end else if (pos_n < shc_pkg::HDR_END) begin
			res.verdict = shc_pkg::V_TRUNCATED;
		end else begin
			res.found_version      = ver_n;
			res.payload_bytes_seen = (cnt_wide[63:32] != '0) ? '1 : cnt_wide[31:0];
			if (ver_n != expected_version) begin
				res.verdict = shc_pkg::V_BAD_VER;
			end else begin
				res.declared_length = len_n;
				if (cnt_n == '1 || cnt_wide != len_n)
					res.verdict = shc_pkg::V_LEN_MISM;
				else if (hash_n != csum_n)
					res.verdict = shc_pkg::V_CSUM_MISM;
				else
					res.verdict = shc_pkg::V_LOADED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			legacy_q <= 1'b0;
			ver_q    <= '0;
			len_q    <= '0;
			csum_q   <= '0;
			hash_q   <= shc_pkg::FNV_BASIS;
			cnt_q    <= '0;
		end else if (step) begin
			if (is_last) begin
				pos_q    <= '0;
				legacy_q <= 1'b0;
				ver_q    <= '0;
				len_q    <= '0;
				csum_q   <= '0;
				hash_q   <= shc_pkg::FNV_BASIS;
				cnt_q    <= '0;
			end else begin
				pos_q    <= pos_n;
				legacy_q <= legacy_n;
				ver_q    <= ver_n;
				len_q    <= len_n;
				csum_q   <= csum_n;
				hash_q   <= hash_n;
				cnt_q    <= cnt_n;
			end
		end
	end

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= shc_pkg::HDR_END)
		else $error("header position past end of header");

	a_legacy_in_magic: assert property (@(posedge clk) disable iff (!arst_n)
		legacy_q |-> pos_q < shc_pkg::HDR_MAGIC_END)
		else $error("legacy flag set after magic completed");

	a_count_after_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> (pos_q == shc_pkg::HDR_END && !legacy_q))
		else $error("payload counted before header done");

endmodule

FILE: design/state_image_header_checker_core.sv
// Top level: input stage, config register and result register around the tracker.
// A last byte passes the input stage register; its verdict is then held in the result register and driven on out_valid.
// Throughput: one byte per cycle; the FNV multiply-xor and the parse of one byte
// fit between the input stage and the tracker state, so bytes go back to back.
// The input stalls only when a last byte meets a result that is still held.
// Reset clears the pipeline, the image state and sets expected_version to 1.
module state_image_header_checker_core #(
	parameter int unsigned COUNT_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           data_byte,
	input  logic                 is_last,
	output logic                 out_valid,
	input  logic                 out_stall,
	output shc_pkg::verdict_t    verdict,
	output logic [31:0]          found_version,
	output logic [63:0]          declared_length,
	output logic [31:0]          payload_bytes_seen,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [31:0]          expected_version
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;
	logic                 fire;
	logic                 in_take;
	logic [31:0]          exp_version_q;
	logic                 out_valid_q;
	shc_pkg::shc_result_t result_q;
	shc_pkg::shc_result_t res;

	assign cfg_ready = 1'b1;

	// a non-last beat never needs the result slot
	assign fire     = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
			last_s1 <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_version_q <= shc_pkg::VERSION_RESET;
		end else if (cfg_valid && cfg_ready) begin
			exp_version_q <= expected_version;
		end
	end

	shc_image_tracker #(
		.COUNT_BITS(COUNT_BITS)
	) u_tracker (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (fire),
		.data_byte        (byte_s1),
		.is_last          (last_s1),
		.expected_version (exp_version_q),
		.res              (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1)
			result_q <= res;
	end

	assign out_valid          = out_valid_q;
	assign verdict            = result_q.verdict;
	assign found_version      = result_q.found_version;
	assign declared_length    = result_q.declared_length;
	assign payload_bytes_seen = result_q.payload_bytes_seen;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && last_s1 && out_valid_q))
		else $error("input stalled without a blocked last beat");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && last_s1) |=> out_valid_q)
		else $error("last beat produced no result");

	a_result_only_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fire && last_s1))
		else $error("result appeared without a last beat");

endmodule

FILE: bench/image_verdict_checker.sv
`timescale 1ns / 100ps
// Watches the byte, result and config channels, predicts each verdict and compares it.
module image_verdict_checker #(
	parameter int unsigned COUNT_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              is_last,
	input  logic              out_valid,
	input  logic              out_stall,
	input  shc_pkg::verdict_t verdict,
	input  logic [31:0]       found_version,
	input  logic [63:0]       declared_length,
	input  logic [31:0]       payload_bytes_seen,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [31:0]       expected_version,
	output int                failures,
	output int                pending
);

	shc_pkg::shc_result_t verdicts_due[$];

	int fail_count = 0;
	int due_count = 0;

	logic [31:0]               want_ver;
	logic [shc_pkg::POS_W-1:0] parse_pos;
	logic                      in_legacy;
	logic [31:0]               hdr_ver;
	logic [63:0]               hdr_len;
	logic [31:0]               hdr_sum;
	logic [31:0]               digest;
	logic [COUNT_BITS-1:0]     payload_cnt;

	assign failures = fail_count;
	assign pending = due_count;

	task automatic flag_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		fail_count++;
	endtask

	task automatic clear_image();
		parse_pos = '0;
		in_legacy = 1'b0;
		hdr_ver = '0;
		hdr_len = '0;
		hdr_sum = '0;
		digest = shc_pkg::FNV_BASIS;
		payload_cnt = '0;
	endtask

	// Fold one accepted byte into the image state; a last byte queues its verdict.
	task automatic parse_byte(input logic [7:0] b, input logic last);
		shc_pkg::shc_result_t r;
		logic [63:0] wide_cnt;
		if (in_legacy) begin
			// rest of a legacy image is dropped
		end else if (parse_pos < shc_pkg::HDR_MAGIC_END) begin
			if (b != shc_pkg::MAGIC[parse_pos[2:0]])
				in_legacy = 1'b1;
			else
				parse_pos++;
		end else if (parse_pos < shc_pkg::HDR_VERSION_END) begin
			hdr_ver[8*(parse_pos - shc_pkg::HDR_MAGIC_END) +: 8] = b;
			parse_pos++;
		end else if (parse_pos < shc_pkg::HDR_LENGTH_END) begin
			hdr_len[8*(parse_pos - shc_pkg::HDR_VERSION_END) +: 8] = b;
			parse_pos++;
		end else if (parse_pos < shc_pkg::HDR_END) begin
			hdr_sum[8*(parse_pos - shc_pkg::HDR_LENGTH_END) +: 8] = b;
			parse_pos++;
		end else begin
			digest = (digest ^ 32'(b)) * shc_pkg::FNV_PRIME;
			if (payload_cnt != '1)
				payload_cnt++;
		end
		if (!last)
			return;
		r = '0;
		if (in_legacy || parse_pos < shc_pkg::HDR_MAGIC_END) begin
			r.verdict = shc_pkg::V_LEGACY;
		end else if (parse_pos < shc_pkg::HDR_END) begin
			r.verdict = shc_pkg::V_TRUNCATED;
		end else begin
			r.found_version = hdr_ver;
			wide_cnt = 64'(payload_cnt);
			r.payload_bytes_seen = (wide_cnt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide_cnt[31:0];
			if (hdr_ver != want_ver) begin
				r.verdict = shc_pkg::V_BAD_VER;
			end else begin
				r.declared_length = hdr_len;
				// a saturated counter never matches, whatever the header says
				if (payload_cnt == '1 || wide_cnt != hdr_len)
					r.verdict = shc_pkg::V_LEN_MISM;
				else if (digest != hdr_sum)
					r.verdict = shc_pkg::V_CSUM_MISM;
				else
					r.verdict = shc_pkg::V_LOADED;
			end
		end
		verdicts_due.insert(verdicts_due.size(), r);
		clear_image();
	endtask

	always @(posedge clk or negedge arst_n) begin
		shc_pkg::shc_result_t want;
		if (!arst_n) begin
			verdicts_due.delete();
			clear_image();
			want_ver = shc_pkg::VERSION_RESET;
			due_count = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				want_ver = expected_version;
			if (out_valid && !out_stall) begin
				if (verdicts_due.size() == 0) begin
					flag_mismatch($sformatf("result beat with nothing expected, verdict %0d",
						verdict));
				end else begin
					want = verdicts_due.pop_front();
					if (verdict !== want.verdict)
						flag_mismatch($sformatf("verdict %0d, expected %0d",
							verdict, want.verdict));
					if (found_version !== want.found_version)
						flag_mismatch($sformatf("found_version %0h, expected %0h",
							found_version, want.found_version));
					if (declared_length !== want.declared_length)
						flag_mismatch($sformatf("declared_length %0h, expected %0h",
							declared_length, want.declared_length));
					if (payload_bytes_seen !== want.payload_bytes_seen)
						flag_mismatch($sformatf("payload_bytes_seen %0d, expected %0d",
							payload_bytes_seen, want.payload_bytes_seen));
				end
			end
			if (in_valid && !in_stall)
				parse_byte(data_byte, is_last);
			due_count = verdicts_due.size();
		end
	end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Bench top: clock, reset, image stimulus with random gaps, and the final verdict.
module testbench;

	// payload counter width for the block and the checker
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned LATENCY = 2;
	localparam int unsigned LIMIT = 1_000_000;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [7:0]        data_byte;
	logic              is_last;
	logic              out_valid;
	logic              out_stall;
	shc_pkg::verdict_t verdict;
	logic [31:0]       found_version;
	logic [63:0]       declared_length;
	logic [31:0]       payload_bytes_seen;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [31:0]       expected_version;

	int failures;
	int pending;
	int unsigned cycle_count = 0;

	logic [7:0]  image_q[$];
	logic [7:0]  payload_q[$];
	logic [31:0] cur_ver;
	bit          quiet = 1'b0;
	int unsigned bytes_sent = 0;

	state_image_header_checker_core #(
		.COUNT_BITS(COUNT_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.verdict(verdict),
		.found_version(found_version),
		.declared_length(declared_length),
		.payload_bytes_seen(payload_bytes_seen),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.expected_version(expected_version)
	);

	image_verdict_checker #(
		.COUNT_BITS(COUNT_W)
	) verdict_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.verdict(verdict),
		.found_version(found_version),
		.declared_length(declared_length),
		.payload_bytes_seen(payload_bytes_seen),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.expected_version(expected_version),
		.failures(failures),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= LIMIT);
		$display("testbench failed");
		$finish;
	end

	// Result side: a random stall, possibly none, ahead of every result beat.
	initial begin
		int unsigned hold;
		out_stall = 1'b0;
		forever begin
			hold = quiet ? 0 : $urandom_range(0, 14);
			repeat (hold) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	task automatic put_byte(input logic [7:0] b, input logic last);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			data_byte <= 8'($urandom);
			is_last <= 1'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= b;
		is_last <= last;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic push_le(input logic [63:0] v, input int nb);
		for (int i = 0; i < nb; i++)
			image_q.insert(image_q.size(), v[8*i +: 8]);
	endtask

	task automatic fill_payload(input int n);
		payload_q.delete();
		repeat (n) payload_q.insert(payload_q.size(), 8'($urandom));
	endtask

	function automatic logic [31:0] payload_digest();
		logic [31:0] h;
		h = shc_pkg::FNV_BASIS;
		foreach (payload_q[i])
			h = (h ^ 32'(payload_q[i])) * shc_pkg::FNV_PRIME;
		return h;
	endfunction

	// Header around payload_q; a nonzero sum_flip spoils the stored checksum.
	task automatic build_image(input logic [31:0] ver, input logic [63:0] declared,
			input logic [31:0] sum_flip);
		image_q.delete();
		for (int i = 0; i < 8; i++)
			image_q.insert(image_q.size(), shc_pkg::MAGIC[i]);
		push_le(64'(ver), 4);
		push_le(declared, 8);
		push_le(64'(payload_digest() ^ sum_flip), 4);
		foreach (payload_q[i])
			image_q.insert(image_q.size(), payload_q[i]);
	endtask

	task automatic trim_image(input int n);
		while (image_q.size() > n)
			void'(image_q.pop_back());
	endtask

	task automatic send_image();
		for (int i = 0; i < image_q.size(); i++)
			put_byte(image_q[i], i == image_q.size() - 1);
		bytes_sent += image_q.size();
	endtask

	task automatic random_image();
		int pick;
		int plen;
		int p;
		logic [31:0] ver;
		logic [63:0] declared;
		logic [31:0] flip;
		pick = $urandom_range(0, 99);
		plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 120) : $urandom_range(0, 12);
		fill_payload(plen);
		ver = ($urandom_range(0, 7) == 0) ? $urandom : cur_ver;
		declared = 64'(plen);
		case ($urandom_range(0, 9))
			0: declared = {$urandom, $urandom};
			1: declared = 64'(plen) + 1;
			2: declared = 64'(plen) - 1;
			default: ;
		endcase
		flip = ($urandom_range(0, 9) == 0) ? ($urandom | 32'd1) : 32'd0;
		build_image(ver, declared, flip);
		if (pick < 55) begin
			// well-formed length of header, whatever its content
		end else if (pick < 70) begin
			trim_image($urandom_range(8, 23));
		end else if (pick < 80) begin
			p = $urandom_range(0, 7);
			image_q[p] = image_q[p] ^ 8'($urandom_range(1, 255));
			if ($urandom_range(0, 1) == 1)
				trim_image($urandom_range(p + 1, image_q.size()));
		end else if (pick < 88) begin
			trim_image($urandom_range(1, 7));
		end else begin
			image_q.delete();
			repeat ($urandom_range(1, 30)) image_q.insert(image_q.size(), 8'($urandom));
		end
		quiet = ($urandom_range(0, 4) == 0);
		send_image();
	endtask

	// Drain: every expected result back, then idle time for the pipeline to empty.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_version(input logic [31:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		expected_version <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] phase_ver [4];
		int unsigned phase_start;
		int phase_images;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		is_last = 1'b0;
		cfg_valid = 1'b0;
		expected_version = '0;
		cur_ver = shc_pkg::VERSION_RESET;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// single byte, not magic
		fill_payload(0);
		build_image(cur_ver, 0, 0);
		trim_image(1);
		image_q[0] = 8'h00;
		send_image();
		// magic cut short: one byte, then seven
		build_image(cur_ver, 0, 0);
		trim_image(1);
		send_image();
		build_image(cur_ver, 0, 0);
		trim_image(7);
		send_image();
		// magic whole, header short
		build_image(cur_ver, 0, 0);
		trim_image(8);
		send_image();
		build_image(cur_ver, 0, 0);
		trim_image(23);
		send_image();
		// magic broken on its first and on its last byte, tail ignored
		fill_payload(4);
		build_image(cur_ver, 4, 0);
		image_q[0] = image_q[0] ^ 8'hFF;
		send_image();
		build_image(cur_ver, 4, 0);
		image_q[7] = image_q[7] ^ 8'h01;
		send_image();
		// empty payload, then single-byte payloads at both extremes
		fill_payload(0);
		build_image(cur_ver, 0, 0);
		send_image();
		fill_payload(1);
		payload_q[0] = 8'hFF;
		build_image(cur_ver, 1, 0);
		send_image();
		payload_q[0] = 8'h00;
		build_image(cur_ver, 1, 0);
		send_image();
		// version extremes against the reset value
		fill_payload(6);
		build_image(32'hFFFF_FFFF, 6, 0);
		send_image();
		build_image(32'h0, 6, 0);
		send_image();
		// length and checksum mismatches
		build_image(cur_ver, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		send_image();
		build_image(cur_ver, 6, 32'hFFFF_FFFF);
		send_image();

		phase_ver = '{32'h0, 32'hFFFF_FFFF, $urandom, shc_pkg::VERSION_RESET};
		for (int k = 0; k < 4; k++) begin
			settle();
			write_version(phase_ver[k]);
			cur_ver = phase_ver[k];
			phase_start = bytes_sent;
			phase_images = 0;
			while (bytes_sent - phase_start < 150 || phase_images < 4) begin
				random_image();
				phase_images++;
			end
		end
		quiet = 1'b0;
		settle();

		if (failures == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

FILE: files.f
design/shc_pkg.sv
design/shc_image_tracker.sv
design/state_image_header_checker_core.sv
bench/image_verdict_checker.sv
bench/testbench.sv
